/* hdl/lfs_pkg.sv */
`default_nettype none

package lfs_pkg;

	localparam int FRAME_LEN = 47;
	localparam int BUF_DEPTH = 64;

	localparam int ADDR_W = $clog2(BUF_DEPTH);
	localparam int FILL_W = $clog2(FRAME_LEN + 1);
	localparam int CNT_W  = ADDR_W + 1;

	localparam logic [7:0] CRC_POLY      = 8'h4d;
	localparam logic [7:0] SYNC_ALT_MASK = 8'(8'h07 << 5);
	localparam logic [7:0] BYTE_MASK     = 8'hff;

	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	typedef enum logic [1:0] {
		IDX_HOLD,
		IDX_ZERO,
		IDX_INC,
		IDX_CRC_LAST
	} idx_op_t;

	typedef enum logic [1:0] {
		DROP_SCAN,
		DROP_TWO,
		DROP_FRAME
	} drop_sel_t;

	typedef struct packed {
		logic      wr;
		logic      rd;
		idx_op_t   idx_op;
		logic      prev_ld;
		logic      latch_p;
		logic      crc_clr;
		logic      crc_upd;
		logic      out_load;
		logic      out_kind;
		logic      drop;
		drop_sel_t drop_sel;
	} lfs_cmd_t;

	typedef struct packed {
		logic fill_ge_last;
		logic fill_lt2;
		logic fill_lt_frame;
		logic pair_hit;
		logic more_pairs;
		logic drop_zero;
		logic crc_more;
		logic crc_ok;
		logic idx_last;
		logic out_free;
	} lfs_sts_t;

	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
		input logic [ADDR_W-1:0] b);
		logic [ADDR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (ADDR_W+1)'(BUF_DEPTH)) begin
			s = s - (ADDR_W+1)'(BUF_DEPTH);
		end
		return s[ADDR_W-1:0];
	endfunction

	// MSB first, no reflection, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if (c[7]) begin
				c = ({c[6:0], 1'b0} ^ CRC_POLY) & BYTE_MASK;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* hdl/lfs_ram.sv */
`default_nettype none

module lfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* hdl/lfs_ctrl.sv */
`default_nettype none

module lfs_ctrl import lfs_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_stall,
	input  wire lfs_sts_t sts,
	output lfs_cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOOP,
		ST_SC_FIRST,
		ST_SC_CMP,
		ST_SC_DONE,
		ST_ERR_SYNC,
		ST_POST,
		ST_CRC_RUN,
		ST_CRC_CHK,
		ST_ERR_CRC,
		ST_EMIT
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.idx_op   = IDX_HOLD;
		cmd.drop_sel = DROP_SCAN;
		cmd.out_kind = KIND_FRAME;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.wr = 1'b1;
					if (sts.fill_ge_last) begin
						state_d = ST_LOOP;
					end
				end
			end
			ST_LOOP: begin
				if (sts.fill_lt2) begin
					state_d = ST_IDLE;
				end else begin
					cmd.idx_op = IDX_ZERO;
					cmd.rd     = 1'b1;
					state_d    = ST_SC_FIRST;
				end
			end
			ST_SC_FIRST: begin
				cmd.prev_ld = 1'b1;
				cmd.idx_op  = IDX_INC;
				cmd.rd      = 1'b1;
				state_d     = ST_SC_CMP;
			end
			ST_SC_CMP: begin
				if (sts.pair_hit || !sts.more_pairs) begin
					cmd.latch_p = 1'b1;
					state_d     = ST_SC_DONE;
				end else begin
					cmd.prev_ld = 1'b1;
					cmd.idx_op  = IDX_INC;
					cmd.rd      = 1'b1;
				end
			end
			ST_SC_DONE: begin
				state_d = sts.drop_zero ? ST_POST : ST_ERR_SYNC;
			end
			ST_ERR_SYNC: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_ERROR;
					cmd.drop     = 1'b1;
					cmd.drop_sel = DROP_SCAN;
					state_d      = ST_POST;
				end
			end
			ST_POST: begin
				if (sts.fill_lt_frame) begin
					state_d = ST_IDLE;
				end else begin
					cmd.crc_clr = 1'b1;
					cmd.idx_op  = IDX_ZERO;
					cmd.rd      = 1'b1;
					state_d     = ST_CRC_RUN;
				end
			end
			ST_CRC_RUN: begin
				cmd.crc_upd = 1'b1;
				cmd.rd      = 1'b1;
				if (sts.crc_more) begin
					cmd.idx_op = IDX_INC;
				end else begin
					cmd.idx_op = IDX_CRC_LAST;
					state_d    = ST_CRC_CHK;
				end
			end
			ST_CRC_CHK: begin
				if (sts.crc_ok) begin
					cmd.idx_op = IDX_ZERO;
					cmd.rd     = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					state_d = ST_ERR_CRC;
				end
			end
			ST_ERR_CRC: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_ERROR;
					cmd.drop     = 1'b1;
					cmd.drop_sel = DROP_TWO;
					state_d      = ST_LOOP;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_kind = KIND_FRAME;
					if (sts.idx_last) begin
						cmd.drop     = 1'b1;
						cmd.drop_sel = DROP_FRAME;
						state_d      = ST_LOOP;
					end else begin
						cmd.idx_op = IDX_INC;
						cmd.rd     = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

/* hdl/lfs_dp.sv */
`default_nettype none

module lfs_dp import lfs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire lfs_cmd_t    cmd,
	output lfs_sts_t         sts,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [7:0]  header_byte,
	input  wire logic [7:0]  ver_len_byte,
	input  wire logic        out_stall,
	output logic             out_valid,
	output logic             kind,
	output logic [7:0]       frame_byte,
	output logic             frame_last,
	output logic [31:0]      error_count
);

	logic [ADDR_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [7:0]        prev_q;
	logic [FILL_W-1:0] drop_q;
	logic [7:0]        crc_q;
	logic [31:0]       err_q;
	logic              out_valid_q;
	logic [FILL_W-1:0] drop_amt;
	logic [7:0]        rdata;
	logic [7:0]        alt_byte;

	lfs_ram #(
		.WIDTH(8),
		.DEPTH(BUF_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(wrap_add(head_q, ADDR_W'(fill_q))),
		.wdata(rx_byte),
		.re   (cmd.rd),
		.raddr(wrap_add(head_q, idx_d)),
		.rdata(rdata)
	);

	assign alt_byte = ver_len_byte | SYNC_ALT_MASK;

	always_comb begin
		case (cmd.idx_op)
			IDX_ZERO:     idx_d = '0;
			IDX_INC:      idx_d = idx_q + 1'b1;
			IDX_CRC_LAST: idx_d = ADDR_W'(FRAME_LEN - 1);
			default:      idx_d = idx_q;
		endcase
	end

	always_comb begin
		case (cmd.drop_sel)
			DROP_TWO:   drop_amt = FILL_W'(2);
			DROP_FRAME: drop_amt = FILL_W'(FRAME_LEN);
			default:    drop_amt = drop_q;
		endcase
	end

	always_comb begin
		sts.fill_ge_last  = fill_q >= FILL_W'(FRAME_LEN - 1);
		sts.fill_lt2      = fill_q < FILL_W'(2);
		sts.fill_lt_frame = fill_q < FILL_W'(FRAME_LEN);
		sts.pair_hit      = (prev_q == header_byte) &&
			((rdata == ver_len_byte) || (rdata == alt_byte));
		sts.more_pairs    = (CNT_W'(idx_q) + CNT_W'(1)) < CNT_W'(fill_q);
		sts.drop_zero     = drop_q == '0;
		sts.crc_more      = idx_q < ADDR_W'(FRAME_LEN - 2);
		sts.crc_ok        = crc_q == rdata;
		sts.idx_last      = idx_q == ADDR_W'(FRAME_LEN - 1);
		sts.out_free      = !out_valid_q || !out_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			fill_q      <= '0;
			idx_q       <= '0;
			err_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			idx_q <= idx_d;
			if (cmd.wr) begin
				fill_q <= fill_q + 1'b1;
			end else if (cmd.drop) begin
				fill_q <= fill_q - drop_amt;
				head_q <= wrap_add(head_q, ADDR_W'(drop_amt));
			end
			if (cmd.out_load && cmd.out_kind == KIND_ERROR) begin
				err_q <= err_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prev_ld) begin
			prev_q <= rdata;
		end
		if (cmd.latch_p) begin
			drop_q <= sts.pair_hit ? FILL_W'(idx_q - 1'b1) : FILL_W'(idx_q);
		end
		if (cmd.crc_clr) begin
			crc_q <= '0;
		end else if (cmd.crc_upd) begin
			crc_q <= crc8_update(crc_q, rdata);
		end
		if (cmd.out_load) begin
			kind <= cmd.out_kind;
			if (cmd.out_kind == KIND_ERROR) begin
				frame_byte  <= '0;
				frame_last  <= 1'b0;
				error_count <= err_q + 1'b1;
			end else begin
				frame_byte  <= rdata;
				frame_last  <= sts.idx_last;
				error_count <= err_q;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a held item");

	a_drop_fits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drop |-> (drop_amt <= fill_q))
		else $error("drop exceeds stored bytes");

	a_fill_inc: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill not advanced on write");

	a_err_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.out_load && cmd.out_kind == KIND_ERROR) |=> (error_count == err_q))
		else $error("error item count mismatch");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> (fill_q < FILL_W'(FRAME_LEN)))
		else $error("write into a complete frame store");
`endif

endmodule

`default_nettype wire

/* hdl/lidar_frame_sync_crc8_core.sv */
// Frame synchronizer for a serial byte stream with a two-byte header and a
// CRC-8 (poly 0x4d) trailer.
// Input channel: rx_byte with in_valid/in_stall, one item per byte.
// Output channel: kind, frame_byte, frame_last, error_count with
// out_valid/out_stall. Each item is a frame byte (kind 0, frame_last on the
// trailer) or a sync/CRC error event (kind 1).
// A byte that does not complete a frame is taken without raising in_stall. The byte that
// completes one starts a pass over the frame store, which has one read
// port: the header scan reads one byte a cycle, the CRC reads one a cycle
// and a good frame is sent at one byte a cycle while out_stall is low; a
// bad CRC drops two bytes and the scan runs again.
// Such a byte keeps in_stall high until the pass ends, also while a result
// waits on out_stall; more than one CRC check can run per byte.
// When the receiver stalls, the result register holds its item and the
// pass waits; nothing is lost.
// Reset clears the store pointers and the error count; header_byte and
// ver_len_byte go to 0x54 and 0x2c. APB registers: 0x0 header_byte,
// 0x4 ver_len_byte; write them only while idle.
`default_nettype none

module lidar_frame_sync_crc8_core import lfs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             kind,
	output logic [7:0]       frame_byte,
	output logic             frame_last,
	output logic [31:0]      error_count
);

	localparam logic REG_HEADER = 1'b0;
	localparam logic REG_VERLEN = 1'b1;

	logic [7:0] header_q;
	logic [7:0] ver_len_q;
	lfs_cmd_t   cmd;
	lfs_sts_t   sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q  <= 8'd84;
			ver_len_q <= 8'd44;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_HEADER: header_q  <= pwdata[7:0];
				REG_VERLEN: ver_len_q <= pwdata[7:0];
				default:    header_q  <= header_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_HEADER: prdata = {24'd0, header_q};
			REG_VERLEN: prdata = {24'd0, ver_len_q};
			default:    prdata = '0;
		endcase
	end

	lfs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	lfs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.rx_byte     (rx_byte),
		.header_byte (header_q),
		.ver_len_byte(ver_len_q),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.kind        (kind),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last),
		.error_count (error_count)
	);

endmodule

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top import lfs_pkg::*; ();

	localparam logic [2:0] REG_HEADER  = 3'd0;
	localparam logic [2:0] REG_VER_LEN = 3'd4;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 500;
	localparam logic [63:0] OPENING_BYTES = 64'h00FF_542C_54EC_AA55;

	typedef struct packed {
		logic        kind;
		logic [7:0]  fbyte;
		logic        last;
		logic [31:0] errs;
	} sync_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        kind;
	logic [7:0]  frame_byte;
	logic        frame_last;
	logic [31:0] error_count;

	logic [7:0]  pend_q[$];
	logic [7:0]  held[$];
	sync_event_t event_q[$];
	logic [7:0]  header_cfg = 8'd84;
	logic [7:0]  ver_len_cfg = 8'd44;
	logic [31:0] err_total = '0;
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;
	int          fail_cnt = 0;
	int          quiet_cycles = 0;

	lidar_frame_sync_crc8_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.frame_byte  (frame_byte),
		.frame_last  (frame_last),
		.error_count (error_count)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
		end
		return c;
	endfunction

	function automatic void note_event(input logic k, input logic [7:0] b, input logic last);
		sync_event_t ev;
		ev.kind  = k;
		ev.fbyte = b;
		ev.last  = last;
		ev.errs  = err_total;
		event_q.push_back(ev);
	endfunction

	// frame sync tracker: runs on every accepted byte
	function automatic void track_byte(input logic [7:0] b);
		int         p;
		logic [7:0] alt;
		logic [7:0] crc;
		alt = ver_len_cfg | SYNC_ALT_MASK;
		if (held.size() < BUF_DEPTH) begin
			held.push_back(b);
		end
		if (held.size() < FRAME_LEN) begin
			return;
		end
		while (held.size() >= 2) begin
			p = 0;
			while (p < held.size() - 1 && !(held[p] == header_cfg &&
				(held[p+1] == ver_len_cfg || held[p+1] == alt))) begin
				p++;
			end
			if (p != 0) begin
				err_total++;
				note_event(KIND_ERROR, 8'h00, 1'b0);
				for (int i = 0; i < p; i++) begin
					void'(held.pop_front());
				end
			end
			if (held.size() < FRAME_LEN) begin
				break;
			end
			crc = 8'h00;
			for (int i = 0; i < FRAME_LEN - 1; i++) begin
				crc = crc8_step(crc, held[i]);
			end
			if (crc == held[FRAME_LEN-1]) begin
				for (int i = 0; i < FRAME_LEN; i++) begin
					note_event(KIND_FRAME, held[i], i == FRAME_LEN - 1);
				end
				for (int i = 0; i < FRAME_LEN; i++) begin
					void'(held.pop_front());
				end
			end else begin
				err_total++;
				note_event(KIND_ERROR, 8'h00, 1'b0);
				void'(held.pop_front());
				void'(held.pop_front());
			end
		end
	endfunction

	// byte driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				track_byte(rx_byte);
			end
			if (!in_valid || !in_stall) begin
				if (pend_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					rx_byte  <= pend_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		sync_event_t want;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
			if ((out_valid && !out_stall) || (in_valid && !in_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (out_valid && !out_stall) begin
				if (event_q.size() == 0) begin
					$display("%0t: unexpected item kind=%0d byte=%h last=%0d count=%0d",
						$time, kind, frame_byte, frame_last, error_count);
					fail_cnt++;
				end else begin
					want = event_q.pop_front();
					if (kind !== want.kind) begin
						$display("%0t: kind expected %0d got %0d", $time, want.kind, kind);
						fail_cnt++;
					end
					if (frame_byte !== want.fbyte) begin
						$display("%0t: frame_byte expected %h got %h",
							$time, want.fbyte, frame_byte);
						fail_cnt++;
					end
					if (frame_last !== want.last) begin
						$display("%0t: frame_last expected %0d got %0d",
							$time, want.last, frame_last);
						fail_cnt++;
					end
					if (error_count !== want.errs) begin
						$display("%0t: error_count expected %0d got %0d",
							$time, want.errs, error_count);
						fail_cnt++;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog, no item moved in %0d cycles", $time, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic apb_write(input logic [2:0] addr, input logic [7:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= {24'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// hold off until every byte is in and every result is out, then let the block settle
	task automatic drain();
		@(negedge clk);
		while (pend_q.size() != 0 || in_valid || event_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// mostly well-formed frames with random body, plus bad CRCs, cut frames and noise
	task automatic queue_stream(input int nbytes);
		int         pushed;
		int         pick;
		int         len;
		logic [7:0] crc;
		logic [7:0] b;
		pushed = 0;
		while (pushed < nbytes) begin
			pick = $urandom_range(99);
			if (pick < 80) begin
				len = (pick < 67) ? FRAME_LEN : $urandom_range(3, FRAME_LEN - 1);
				if (len > nbytes - pushed) begin
					len = nbytes - pushed;
				end
				crc = 8'h00;
				for (int i = 0; i < len; i++) begin
					if (i == 0) begin
						b = header_cfg;
					end else if (i == 1) begin
						b = $urandom_range(1) ? ver_len_cfg : (ver_len_cfg | SYNC_ALT_MASK);
					end else if (i == FRAME_LEN - 1) begin
						b = (pick < 55) ? crc : (crc ^ 8'($urandom_range(1, 255)));
					end else begin
						b = 8'($urandom_range(255));
					end
					crc = crc8_step(crc, b);
					pend_q.push_back(b);
				end
				pushed += len;
			end else begin
				len = $urandom_range(1, 12);
				if (len > nbytes - pushed) begin
					len = nbytes - pushed;
				end
				for (int i = 0; i < len; i++) begin
					pend_q.push_back(8'($urandom_range(255)));
				end
				pushed += len;
			end
		end
	endtask

	task automatic run_phase(input logic [7:0] hdr, input logic [7:0] ver,
		input int send_pct, input int recv_pct, input int nbytes);
		drain();
		apb_write(REG_HEADER, hdr);
		apb_write(REG_VER_LEN, ver);
		@(negedge clk);
		header_cfg     = hdr;
		ver_len_cfg    = ver;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		queue_stream(nbytes);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// junk with extreme bytes and two stray header pairs, then random frames
		for (int i = 7; i >= 0; i--) begin
			pend_q.push_back(OPENING_BYTES[i*8 +: 8]);
		end
		queue_stream(60);
		run_phase(8'hFF, 8'h00, 47, 0, 50);
		run_phase(8'h00, 8'hFF, 0, 47, 50);
		run_phase(8'($urandom_range(255)), 8'($urandom_range(255)), 17, 17, 50);
		run_phase(8'd84, 8'd44, 0, 0, 50);
		drain();
		if (fail_cnt == 0 && event_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
